[rtl/core/i2c_bit_level_master_top_macros.svh]
// assertion macros for the i2c bit-level master
// used by the top level only; expects clk and rst_n in scope
`ifndef I2C_BIT_LEVEL_MASTER_TOP_MACROS_SVH
`define I2C_BIT_LEVEL_MASTER_TOP_MACROS_SVH

// same-cycle implication, checked out of reset
`define I2CBM_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("i2cbm same-cycle check failed");

// next-cycle implication, checked out of reset
`define I2CBM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("i2cbm next-cycle check failed");

`endif

[rtl/core/i2cbm_pkg.sv]
// shared types and constants for the i2c bit-level master
// no dependencies
package i2cbm_pkg;

  typedef enum logic [2:0] {
    CMD_NONE  = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_WRITE = 3'd3,
    CMD_READ  = 3'd4
  } cmd_t;

  // one classified tick
  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] wr_byte;
    logic       ack_level;
    logic       sda_in;
  } item_t;

  // one result, scl_level in bit 0
  typedef struct packed {
    logic       ack_seen;
    logic [7:0] rd_data;
    logic       done_res;
    logic       busy_res;
    logic       sda_drive;
    logic       sda_level;
    logic       scl_level;
  } res_t;

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 16;
  localparam int RES_W       = $bits(res_t);

  localparam logic [7:0] PHASE_TICKS_RST = 8'd8;
  localparam logic [4:0] PH_BYTE_END     = 5'd16;
  localparam logic [4:0] PH_ACK_HIGH     = 5'd17;
  localparam logic [4:0] PH_COUNT_SHORT  = 5'd3;
  localparam logic [4:0] PH_COUNT_LONG   = 5'd18;

endpackage

[rtl/core/i2cbm_front.sv]
// front end: decodes request codes and buffers ticks in a two-entry queue
// depends on i2cbm_pkg
module i2cbm_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [2:0]            in_req_type,
  input  logic [7:0]            in_wr_byte,
  input  logic                  in_ack_level,
  input  logic                  in_sda_in,
  input  logic                  q_pop,
  output logic                  q_vld,
  output i2cbm_pkg::item_t      q_item
);
  import i2cbm_pkg::*;

  item_t      mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  item_t      item_in;

  always_comb begin
    item_in.wr_byte   = in_wr_byte;
    item_in.ack_level = in_ack_level;
    item_in.sda_in    = in_sda_in;
    // codes above read behave as no request
    unique case (in_req_type)
      CMD_START: item_in.cmd = CMD_START;
      CMD_STOP:  item_in.cmd = CMD_STOP;
      CMD_WRITE: item_in.cmd = CMD_WRITE;
      CMD_READ:  item_in.cmd = CMD_READ;
      default:   item_in.cmd = CMD_NONE;
    endcase
  end

  assign in_tready = (cnt_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign q_vld     = (cnt_r != 2'd0);
  assign q_item    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

[rtl/core/i2cbm_back.sv]
// back end: pin sequencer for start, stop, write and read, plus result register
// depends on i2cbm_pkg
module i2cbm_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [7:0]            cfg_phase_ticks,
  input  logic                  q_vld,
  input  i2cbm_pkg::item_t      q_item,
  output logic                  q_pop,
  output logic                  out_vld,
  input  logic                  out_rdy,
  output i2cbm_pkg::res_t       out_res
);
  import i2cbm_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_START = 5'b00010,
    ST_STOP  = 5'b00100,
    ST_WRITE = 5'b01000,
    ST_READ  = 5'b10000
  } st_t;

  typedef struct packed {
    logic scl;
    logic sda;
    logic drv;
  } pins_t;

  function automatic pins_t set_pins(st_t st, logic [4:0] p, logic [7:0] sh,
                                     logic ack, pins_t cur);
    pins_t r;
    r = cur;
    unique case (st)
      ST_START: begin
        r.drv = 1'b1;
        r.scl = (p != 5'd0);
        r.sda = (p != 5'd2);
      end
      ST_STOP: begin
        r.drv = 1'b1;
        r.scl = (p != 5'd0);
        r.sda = (p == 5'd2);
      end
      ST_WRITE: begin
        r.scl = p[0];
        if (p < PH_BYTE_END) begin
          r.drv = 1'b1;
          r.sda = sh[3'd7 - p[3:1]];
        end else begin
          r.drv = 1'b0;
          r.sda = 1'b1;
        end
      end
      ST_READ: begin
        r.scl = p[0];
        if (p < PH_BYTE_END) begin
          r.drv = 1'b0;
          r.sda = 1'b1;
        end else begin
          r.drv = 1'b1;
          r.sda = ack;
        end
      end
      default: r = cur;
    endcase
    return r;
  endfunction

  st_t        st_r, st_a, st_nxt;
  logic [7:0] tick_r, tick_a, tick_nxt;
  logic [4:0] phase_r, phase_a, phase_nxt;
  logic [7:0] shift_r, shift_a, shift_nxt;
  logic       ackc_r, ackc_a;
  pins_t      pins_r, pins_a, pins_nxt;
  logic       nack_r, nack_nxt;
  logic [7:0] rd_r, rd_nxt;
  logic [7:0] ticks_r;
  logic [7:0] limit;
  logic [8:0] tick_sum;
  logic [4:0] phase_inc;
  logic [4:0] ph_count;
  logic       out_vld_r;
  res_t       out_res_r, res_nxt;

  assign limit   = (ticks_r == 8'd0) ? 8'd1 : ticks_r;
  assign q_pop   = q_vld && (!out_vld_r || out_rdy);
  assign out_vld = out_vld_r;
  assign out_res = out_res_r;

  always_comb begin
    st_a    = st_r;
    tick_a  = tick_r;
    phase_a = phase_r;
    shift_a = shift_r;
    ackc_a  = ackc_r;
    pins_a  = pins_r;
    // a new command is taken only while idle
    if (st_r == ST_IDLE && q_item.cmd != CMD_NONE) begin
      unique case (q_item.cmd)
        CMD_START: st_a = ST_START;
        CMD_STOP:  st_a = ST_STOP;
        CMD_WRITE: st_a = ST_WRITE;
        CMD_READ:  st_a = ST_READ;
        default:   st_a = ST_IDLE;
      endcase
      tick_a  = 8'd0;
      phase_a = 5'd0;
      shift_a = (q_item.cmd == CMD_WRITE) ? q_item.wr_byte : 8'd0;
      ackc_a  = q_item.ack_level;
      pins_a  = set_pins(st_a, 5'd0, shift_a, ackc_a, pins_r);
    end

    st_nxt    = st_a;
    tick_nxt  = tick_a;
    phase_nxt = phase_a;
    shift_nxt = shift_a;
    pins_nxt  = pins_a;
    nack_nxt  = nack_r;
    rd_nxt    = rd_r;
    tick_sum  = {1'b0, tick_a} + 9'd1;
    phase_inc = phase_a + 5'd1;
    ph_count  = (st_a == ST_START || st_a == ST_STOP) ? PH_COUNT_SHORT : PH_COUNT_LONG;

    res_nxt.scl_level = pins_a.scl;
    res_nxt.sda_level = pins_a.sda;
    res_nxt.sda_drive = pins_a.drv;
    res_nxt.busy_res  = (st_a != ST_IDLE);
    res_nxt.done_res  = 1'b0;

    if (st_a != ST_IDLE) begin
      if (tick_sum >= {1'b0, limit}) begin
        tick_nxt = 8'd0;
        // sample on the last tick of each scl-high data phase
        if (st_a == ST_READ && phase_a < PH_BYTE_END && phase_a[0]) begin
          shift_nxt = {shift_a[6:0], q_item.sda_in};
        end
        if (st_a == ST_WRITE && phase_a == PH_ACK_HIGH) begin
          nack_nxt = q_item.sda_in;
        end
        if (phase_inc >= ph_count) begin
          if (st_a == ST_READ) begin
            rd_nxt = shift_nxt;
          end
          res_nxt.done_res = 1'b1;
          st_nxt    = ST_IDLE;
          phase_nxt = 5'd0;
        end else begin
          phase_nxt = phase_inc;
          pins_nxt  = set_pins(st_a, phase_inc, shift_nxt, ackc_a, pins_a);
        end
      end else begin
        tick_nxt = tick_sum[7:0];
      end
    end

    res_nxt.rd_data  = rd_nxt;
    res_nxt.ack_seen = nack_nxt;
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_res_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= ST_IDLE;
      tick_r    <= 8'd0;
      phase_r   <= 5'd0;
      shift_r   <= 8'd0;
      ackc_r    <= 1'b0;
      pins_r    <= '{scl: 1'b1, sda: 1'b1, drv: 1'b1};
      nack_r    <= 1'b0;
      rd_r      <= 8'd0;
      ticks_r   <= PHASE_TICKS_RST;
      out_vld_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        ticks_r <= cfg_phase_ticks;
      end
      if (q_pop) begin
        st_r    <= st_nxt;
        tick_r  <= tick_nxt;
        phase_r <= phase_nxt;
        shift_r <= shift_nxt;
        ackc_r  <= ackc_a;
        pins_r  <= pins_nxt;
        nack_r  <= nack_nxt;
        rd_r    <= rd_nxt;
      end
      if (q_pop) begin
        out_vld_r <= 1'b1;
      end else if (out_rdy) begin
        out_vld_r <= 1'b0;
      end
    end
  end

endmodule

[rtl/core/i2c_bit_level_master_top.sv]
// i2c bit-level master, top level: front decoder/queue and back pin sequencer
// depends on i2cbm_pkg, i2cbm_front, i2cbm_back, i2c_bit_level_master_top_macros.svh
//
//   channel | direction | contents
//   in_     | slave     | one bus tick: request kind, write byte, ack level, sampled sda
//   out_    | master    | one result per tick: pins, busy, done, read byte, ack seen
//   cfg_    | slave     | phase_ticks write
//
// one tick is taken per cycle while the queue has room; it is first written into the
// queue, and its result is registered in the output register when it is popped.
// reset brings scl and sda high and driven, phase_ticks to 8, queue and output empty.
// a stalled output holds the back end; the front keeps taking ticks until the
// queue is full.
module i2c_bit_level_master_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [7:0] wr_byte, [8] ack_level, [9] sda_in, [15:10] zero
  input  logic [i2cbm_pkg::IN_TDATA_W-1:0]  in_tdata,
  // [2:0] req_type
  input  logic [2:0]                        in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [0] scl_level, [1] sda_level, [2] sda_drive, [3] busy_res, [4] done_res,
  // [12:5] rd_data, [13] ack_seen, [15:14] zero
  output logic [i2cbm_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [7:0]                        cfg_data
);
  import i2cbm_pkg::*;

  `include "i2c_bit_level_master_top_macros.svh"

  logic  q_pop;
  logic  q_vld;
  item_t q_item;
  res_t  out_res;

  assign cfg_ready = 1'b1;

  i2cbm_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_req_type  (in_tuser),
    .in_wr_byte   (in_tdata[7:0]),
    .in_ack_level (in_tdata[8]),
    .in_sda_in    (in_tdata[9]),
    .q_pop        (q_pop),
    .q_vld        (q_vld),
    .q_item       (q_item)
  );

  i2cbm_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_phase_ticks (cfg_data),
    .q_vld           (q_vld),
    .q_item          (q_item),
    .q_pop           (q_pop),
    .out_vld         (out_tvalid),
    .out_rdy         (out_tready),
    .out_res         (out_res)
  );

  assign out_tdata = {{(OUT_TDATA_W - RES_W){1'b0}}, out_res};

  // a finishing tick is always a busy tick
  `I2CBM_ASSERT_IMPL(a_done_busy, out_tvalid && out_res.done_res, out_res.busy_res)
  // released sda reads high
  `I2CBM_ASSERT_IMPL(a_release_high, out_tvalid && !out_res.sda_drive, out_res.sda_level)
  // front only backs up when the queue holds work
  `I2CBM_ASSERT_IMPL(a_full_has_work, !in_tready, q_vld)
  // a popped tick always lands in the output register
  `I2CBM_ASSERT_NEXT(a_pop_shows, q_pop, out_tvalid)

endmodule
